FILE: rtl/symmetric_kl_divergence_diag_gauss_top_macros.svh
// Assertion macros for the symmetric KL divergence block.
// Included by the top level; no other dependencies.
`ifndef SYMMETRIC_KL_DIVERGENCE_DIAG_GAUSS_TOP_MACROS_SVH
`define SYMMETRIC_KL_DIVERGENCE_DIAG_GAUSS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define SKL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Next-cycle implication, checked outside reset.
`define SKL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define SKL_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SKL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/skl_pkg.sv
// Shared types and constants for the symmetric KL divergence block.
// No dependencies; imported by skl_div and the top level.
`default_nettype none
package skl_pkg;

    localparam int FRAC_BITS_DEF = 8;   // default fraction bits of the inputs
    localparam int IN_W          = 16;  // width of means and variances
    localparam int DEN_W         = 32;  // width of va*vb
    localparam int SUM_W         = 56;  // running sum width, Q.16
    localparam int OUT_W         = 32;  // result width, Q16.16
    localparam int OUT_FRAC      = 16;
    localparam int STAT_W        = 2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } skl_div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/skl_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on skl_pkg for DEN_W and the status struct.
`default_nettype none
module skl_div import skl_pkg::*; #(
    parameter int NUM_W = 58
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0]      quotient,
    output skl_div_stat_t         stat
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

FILE: rtl/symmetric_kl_divergence_diag_gauss_top.sv
// Channel | Ports                                   | Transfer when
// s_      | target/cand mean+var, last_dim, flags   | s_valid && s_ready
// m_      | divergence (Q16.16), status             | m_valid && m_ready
//
// Each dimension is accepted, takes four passes on the shared 32x32 multiplier,
// loads the radix-2 divider with a NUM_W = 66 - FRAC_BITS bit numerator (58 at
// the default), waits for its quotient, picks it up and accumulates it.
// A last item then loads the result register; a last item with a flag set
// skips the arithmetic and goes straight to the result register.
// s_ready is high only in the idle state. A result waits in the output
// register while the next vector streams in; only the next result stalls on it.
// Reset (aresetn, synchronous, active low) clears the sequencer, sum and flags.
//
// Depends on skl_pkg, skl_div and the macro header.
`default_nettype none
`include "symmetric_kl_divergence_diag_gauss_top_macros.svh"
module symmetric_kl_divergence_diag_gauss_top import skl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [IN_W-1:0] s_target_mean,
    input  wire logic [IN_W-1:0]   s_target_var,
    input  wire logic signed [IN_W-1:0] s_cand_mean,
    input  wire logic [IN_W-1:0]   s_cand_var,
    input  wire logic              s_last_dim,
    input  wire logic              s_target_absent,
    input  wire logic              s_length_mismatch,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [OUT_W-1:0]       m_divergence,
    output logic [STAT_W-1:0]      m_status
);
    // Numerator: (vd^2 << 16) + (ad^2 * (va+vb) << (16 - FRAC_BITS)), plus a carry bit.
    localparam int NUM_W   = 66 - FRAC_BITS;
    localparam int ACC_W   = ((NUM_W > SUM_W) ? NUM_W : SUM_W) + 1;
    localparam int PROD4_W = 2 * IN_W + IN_W + 1;   // ad^2 * (va+vb)

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_VD,
        ST_MUL_AD,
        ST_MUL_NUM,
        ST_DIV,
        ST_ACC,
        ST_FIN
    } state_t;

    state_t                state_reg;
    logic [IN_W-1:0]       va_reg, vb_reg, ad_reg, vd_reg;
    logic [IN_W:0]         vs_reg;
    logic                  last_reg, absent_reg, mis_reg;
    logic [2*DEN_W-1:0]    prod_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [2*IN_W-1:0]     vd2_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  ovf_reg;
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      div_out_reg;
    logic [STAT_W-1:0]     stat_out_reg;

    logic [IN_W-1:0]       va_in, vb_in;
    logic signed [IN_W:0]  diff_in;
    logic [DEN_W-1:0]      mul_a, mul_b;
    logic [2*DEN_W-1:0]    mul_p;
    logic [NUM_W-1:0]      num_val;
    logic [NUM_W-1:0]      quotient;
    logic [ACC_W-1:0]      sum_wide;
    logic [SUM_W-3:0]      quarter;
    logic                  div_start;
    logic                  out_free;
    skl_div_stat_t         div_stat;

    // raise zero variances to one LSB; mean difference needs one extra bit
    assign va_in   = (s_target_var == '0) ? IN_W'(1) : s_target_var;
    assign vb_in   = (s_cand_var == '0) ? IN_W'(1) : s_cand_var;
    assign diff_in = (IN_W+1)'(s_target_mean) - (IN_W+1)'(s_cand_mean);

    // shared multiplier: va*vb, vd*vd, ad*ad, then ad^2 * (va+vb)
    always_comb begin
        unique case (state_reg)
            ST_MUL_DEN: begin
                mul_a = DEN_W'(va_reg);
                mul_b = DEN_W'(vb_reg);
            end
            ST_MUL_VD: begin
                mul_a = DEN_W'(vd_reg);
                mul_b = DEN_W'(vd_reg);
            end
            ST_MUL_AD: begin
                mul_a = DEN_W'(ad_reg);
                mul_b = DEN_W'(ad_reg);
            end
            ST_MUL_NUM: begin
                mul_a = prod_reg[DEN_W-1:0];
                mul_b = DEN_W'(vs_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign num_val = NUM_W'({vd2_reg, {OUT_FRAC{1'b0}}})
                   + (NUM_W'(prod_reg[PROD4_W-1:0]) << (OUT_FRAC - FRAC_BITS));
    assign div_start = (state_reg == ST_DIV) && !div_stat.busy && !div_stat.done
                       && (prod_reg != '1);

    skl_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (num_val),
        .den      (den_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign sum_wide = ACC_W'(sum_reg) + ACC_W'(quotient);
    assign quarter  = sum_reg[SUM_W-1:2];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
            absent_reg  <= 1'b0;
            mis_reg     <= 1'b0;
            prod_reg    <= '0;
        end else begin
            // drop the result once the sink takes it, unless a new one replaces it
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        va_reg     <= va_in;
                        vb_reg     <= vb_in;
                        vs_reg     <= (IN_W+1)'(va_in) + (IN_W+1)'(vb_in);
                        vd_reg     <= (va_in > vb_in) ? va_in - vb_in : vb_in - va_in;
                        ad_reg     <= diff_in[IN_W] ? IN_W'(-diff_in) : IN_W'(diff_in);
                        last_reg   <= s_last_dim;
                        absent_reg <= s_last_dim && s_target_absent;
                        mis_reg    <= s_last_dim && s_length_mismatch;
                        // flagged last items skip the arithmetic
                        if (s_last_dim && (s_target_absent || s_length_mismatch)) begin
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_MUL_DEN;
                        end
                    end
                end
                ST_MUL_DEN: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_VD;
                end
                ST_MUL_VD: begin
                    den_reg   <= prod_reg[DEN_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_AD;
                end
                ST_MUL_AD: begin
                    vd2_reg   <= prod_reg[2*IN_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_NUM;
                end
                ST_MUL_NUM: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // hold until the divider finishes
                    if (div_stat.done) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (sum_wide > ACC_W'({SUM_W{1'b1}})) begin
                        sum_reg <= '1;
                        ovf_reg <= 1'b1;
                    end else begin
                        sum_reg <= sum_wide[SUM_W-1:0];
                    end
                    state_reg <= last_reg ? ST_FIN : ST_IDLE;
                end
                ST_FIN: begin
                    // wait for the output register to free up
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        priority if (absent_reg) begin
                            div_out_reg  <= '0;
                            stat_out_reg <= STAT_ABSENT;
                        end else if (mis_reg) begin
                            div_out_reg  <= OUT_W'(1) << OUT_FRAC;
                            stat_out_reg <= STAT_MISMATCH;
                        end else if (ovf_reg || (quarter[SUM_W-3:OUT_W] != '0)) begin
                            div_out_reg  <= '1;
                            stat_out_reg <= STAT_SAT;
                        end else begin
                            div_out_reg  <= quarter[OUT_W-1:0];
                            stat_out_reg <= STAT_OK;
                        end
                        sum_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_divergence = div_out_reg;
    assign m_status     = stat_out_reg;

    // divider never runs while the block takes a new item
    `SKL_ASSERT_NOW(a_idle_div_quiet, aclk, aresetn, s_ready, !div_stat.busy)
    // a result is loaded whenever the final state finds the output free
    `SKL_ASSERT_NEXT(a_fin_loads, aclk, aresetn, (state_reg == ST_FIN) && out_free, m_valid)
    // a saturated result always carries the all-ones value
    `SKL_ASSERT_NOW(a_sat_value, aclk, aresetn, m_valid && (m_status == STAT_SAT),
                    m_divergence == '1)

endmodule
`default_nettype wire

FILE: bench/kl_divergence_checker.sv
`timescale 1ns / 100ps
// Channel checker for the symmetric KL divergence block: watches the input and
// result transfers, predicts each result and compares it in order.
// Depends on skl_pkg for widths and status codes.
module kl_divergence_checker import skl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [IN_W-1:0]   s_target_mean,
    input  logic [IN_W-1:0]          s_target_var,
    input  logic signed [IN_W-1:0]   s_cand_mean,
    input  logic [IN_W-1:0]          s_cand_var,
    input  logic                     s_last_dim,
    input  logic                     s_target_absent,
    input  logic                     s_length_mismatch,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [OUT_W-1:0]         m_divergence,
    input  logic [STAT_W-1:0]        m_status,
    output int                       mismatch_count,
    output int                       results_owed
);

    localparam logic [63:0] SUM_CEILING = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] OUT_CEILING = (64'd1 << OUT_W) - 64'd1;
    localparam logic [63:0] ONE_Q16     = 64'd1 << OUT_FRAC;

    typedef struct packed {
        logic [OUT_W-1:0]  divergence;
        logic [STAT_W-1:0] status;
    } kl_result_t;

    kl_result_t  owed_results[$];
    logic [63:0] dim_sum;
    logic        sum_clipped;

    // One dimension's divergence term in Q.16, truncated; exact integer fraction.
    function automatic logic [63:0] kl_term_q16(input logic signed [IN_W-1:0] tm,
                                                 input logic [IN_W-1:0] tv,
                                                 input logic signed [IN_W-1:0] cm,
                                                 input logic [IN_W-1:0] cv);
        logic [63:0]        va, vb, ad, vd, num;
        logic signed [17:0] diff;
        va   = (tv == '0) ? 64'd1 : 64'(tv);
        vb   = (cv == '0) ? 64'd1 : 64'(cv);
        diff = {{2{tm[IN_W-1]}}, tm} - {{2{cm[IN_W-1]}}, cm};
        ad   = diff[17] ? 64'(-diff) : 64'(diff);
        vd   = (va > vb) ? va - vb : vb - va;
        num  = ((vd * vd) << OUT_FRAC) + (((ad * ad) * (va + vb)) << (OUT_FRAC - FRAC_BITS));
        return num / (va * vb);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        kl_result_t  want;
        logic [63:0] term;
        logic [63:0] quarter;
        if (!aresetn) begin
            owed_results.delete();
            dim_sum        = '0;
            sum_clipped    = 1'b0;
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_last_dim && (s_target_absent || s_length_mismatch)) begin
                    // flagged vector end: data ignored, absent wins over mismatch
                    want.divergence = s_target_absent ? '0 : ONE_Q16[OUT_W-1:0];
                    want.status     = s_target_absent ? STAT_ABSENT : STAT_MISMATCH;
                    owed_results.push_back(want);
                    dim_sum     = '0;
                    sum_clipped = 1'b0;
                end else begin
                    term = kl_term_q16(s_target_mean, s_target_var, s_cand_mean, s_cand_var);
                    if (term > SUM_CEILING - dim_sum) begin
                        dim_sum     = SUM_CEILING;
                        sum_clipped = 1'b1;
                    end else begin
                        dim_sum = dim_sum + term;
                    end
                    if (s_last_dim) begin
                        quarter = dim_sum >> 2;
                        if (sum_clipped || quarter > OUT_CEILING) begin
                            want.divergence = OUT_CEILING[OUT_W-1:0];
                            want.status     = STAT_SAT;
                        end else begin
                            want.divergence = quarter[OUT_W-1:0];
                            want.status     = STAT_OK;
                        end
                        owed_results.push_back(want);
                        dim_sum     = '0;
                        sum_clipped = 1'b0;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_divergence), '0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_divergence !== want.divergence)
                        report_mismatch("divergence", 64'(m_divergence), 64'(want.divergence));
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                end
            end
        end
        results_owed <= owed_results.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bench for the symmetric KL divergence block: clock, reset,
// stimulus and verdict. Depends on skl_pkg, the block and kl_divergence_checker.
module testbench;
    import skl_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;       // final stretch without any idling
    localparam int DRAIN_CYCLES = 150;       // drain wait after the last owed result
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                   aclk              = 1'b0;
    logic                   aresetn           = 1'b0;
    logic                   s_valid           = 1'b0;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_target_mean     = '0;
    logic [IN_W-1:0]        s_target_var      = '0;
    logic signed [IN_W-1:0] s_cand_mean       = '0;
    logic [IN_W-1:0]        s_cand_var        = '0;
    logic                   s_last_dim        = 1'b0;
    logic                   s_target_absent   = 1'b0;
    logic                   s_length_mismatch = 1'b0;
    logic                   m_valid;
    logic                   m_ready           = 1'b0;
    logic [OUT_W-1:0]       m_divergence;
    logic [STAT_W-1:0]      m_status;

    int   mismatch_count;
    int   results_owed;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;    // set for the last part of the run: no idling

    symmetric_kl_divergence_diag_gauss_top #(
        .FRAC_BITS(FRAC)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_mean     (s_target_mean),
        .s_target_var      (s_target_var),
        .s_cand_mean       (s_cand_mean),
        .s_cand_var        (s_cand_var),
        .s_last_dim        (s_last_dim),
        .s_target_absent   (s_target_absent),
        .s_length_mismatch (s_length_mismatch),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_divergence      (m_divergence),
        .m_status          (m_status)
    );

    kl_divergence_checker #(
        .FRAC_BITS(FRAC)
    ) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_mean     (s_target_mean),
        .s_target_var      (s_target_var),
        .s_cand_mean       (s_cand_mean),
        .s_cand_var        (s_cand_var),
        .s_last_dim        (s_last_dim),
        .s_target_absent   (s_target_absent),
        .s_length_mismatch (s_length_mismatch),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_divergence      (m_divergence),
        .m_status          (m_status),
        .mismatch_count    (mismatch_count),
        .results_owed      (results_owed)
    );

    // 20 ns clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: abort the run if it hangs, e.g. on a result that never comes.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: alternate random stall bursts with random ready stretches;
    // hold ready high for good once the calm phase begins.
    initial begin
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // Present one dimension and hold it until the transfer. Valid stays high
    // afterwards so back-to-back items never toggle it within one time step.
    task automatic send_dim(input logic [IN_W-1:0] tm, input logic [IN_W-1:0] tv,
                            input logic [IN_W-1:0] cm, input logic [IN_W-1:0] cv,
                            input logic last, input logic absent, input logic mismatch);
        s_valid           <= 1'b1;
        s_target_mean     <= tm;
        s_target_var      <= tv;
        s_cand_mean       <= cm;
        s_cand_var        <= cv;
        s_last_dim        <= last;
        s_target_absent   <= absent;
        s_length_mismatch <= mismatch;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (items_sent >= RANDOM_ITEMS - CALM_ITEMS)
            calm <= 1'b1;
    endtask

    // Drop valid for a burst of idle cycles.
    task automatic pause_send(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // One vector pair with random content. Wide vectors use the full field
    // ranges (these mostly saturate); narrow ones use realistic variances
    // near 1.0 and close means so the sum lands in range.
    task automatic send_random_vector(input int dims, input bit wide);
        logic [IN_W-1:0] tm, tv, cm, cv;
        logic            absent, mismatch;
        int              flag_roll;
        flag_roll = $urandom_range(0, 9);
        for (int i = 0; i < dims; i++) begin
            if (wide) begin
                tm = IN_W'($urandom);
                tv = IN_W'($urandom);
                cm = IN_W'($urandom);
                cv = IN_W'($urandom);
            end else begin
                tv = IN_W'($urandom_range(32, 1024));
                cv = IN_W'($urandom_range(32, 1024));
                tm = IN_W'($urandom_range(0, 2047)) - IN_W'(1024);
                cm = tm + IN_W'($urandom_range(0, 255)) - IN_W'(128);
            end
            // exercise the zero-variance floor now and then
            if ($urandom_range(0, 15) == 0) tv = '0;
            if ($urandom_range(0, 15) == 0) cv = '0;
            if (i == dims - 1) begin
                absent   = (flag_roll == 0);
                mismatch = (flag_roll == 1) || (flag_roll == 0 && $urandom_range(0, 1) == 1);
            end else begin
                // flags on inner dimensions must be ignored
                absent   = ($urandom_range(0, 3) == 0);
                mismatch = ($urandom_range(0, 3) == 0);
            end
            if (!calm && $urandom_range(0, 3) == 0)
                pause_send($urandom_range(1, 15));
            send_dim(tm, tv, cm, cv, i == dims - 1, absent, mismatch);
        end
    endtask

    initial begin
        // Hold reset at the start, then release it once.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // all zero: both variances floored to one LSB, equal means, zero term
        send_dim(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
        // mean extremes against variance extremes: result saturates
        send_dim(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_dim(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 1'b0);
        // identical unit Gaussians: zero
        send_dim(16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b1, 1'b0, 1'b0);
        // identical at the top variance and bottom mean: zero
        send_dim(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        // variance ratio of two only: quarter of 0.5
        send_dim(16'h0000, 16'h0001, 16'h0000, 16'h0002, 1'b1, 1'b0, 1'b0);
        // three dimensions with flags on the inner items, which are ignored
        send_dim(16'h0080, 16'h0100, 16'hFF80, 16'h0200, 1'b0, 1'b1, 1'b1);
        send_dim(16'h0200, 16'h0040, 16'h0180, 16'h0080, 1'b0, 1'b1, 1'b0);
        send_dim(16'hFE00, 16'h0300, 16'hFE40, 16'h0100, 1'b1, 1'b0, 1'b0);
        // target absent together with a length mismatch: absent wins
        send_dim(16'h1234, 16'h0100, 16'h4321, 16'h0200, 1'b0, 1'b0, 1'b0);
        send_dim(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b1, 1'b1);
        // length mismatch alone: 1.0
        send_dim(16'h0100, 16'h0100, 16'h0000, 16'h0100, 1'b0, 1'b0, 1'b0);
        send_dim(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001, 1'b1, 1'b0, 1'b1);
        // target absent alone, after a gap
        pause_send(5);
        send_dim(16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        // the sum must have been cleared by the flagged end
        send_dim(16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b1, 1'b0, 1'b0);

        // Random part: mostly short vectors, a few long ones.
        while (items_sent < RANDOM_ITEMS) begin
            send_random_vector(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(1, 6),
                               $urandom_range(0, 2) == 0);
        end
        s_valid <= 1'b0;

        // Drain: wait for every owed result, then give the block time to show
        // anything extra.
        do @(posedge aclk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: symmetric_kl_divergence_diag_gauss_top.f
+incdir+rtl
rtl/skl_pkg.sv
rtl/skl_div.sv
rtl/symmetric_kl_divergence_diag_gauss_top.sv
bench/kl_divergence_checker.sv
bench/testbench.sv
